@@ rtl/mcu_mailbox_port_interface_core_defines.svh @@
// Assertion macros for the mailbox port interface core.
// Used by the top level only; no other dependencies.
`ifndef MCU_MAILBOX_PORT_INTERFACE_CORE_DEFINES_SVH
`define MCU_MAILBOX_PORT_INTERFACE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MMPI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmpi: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define MMPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmpi: next-cycle check failed");

`endif

@@ rtl/mmpi_pkg.sv @@
// Shared types and constants for the mailbox port interface core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mmpi_pkg;

  // Access codes
  localparam logic [3:0] MODE_MAIN_WRITE  = 4'd0;
  localparam logic [3:0] MODE_MAIN_READ   = 4'd1;
  localparam logic [3:0] MODE_MAIN_STATUS = 4'd2;
  localparam logic [3:0] MODE_A_READ      = 4'd3;
  localparam logic [3:0] MODE_A_WRITE     = 4'd4;
  localparam logic [3:0] MODE_A_DDR       = 4'd5;
  localparam logic [3:0] MODE_B_READ      = 4'd6;
  localparam logic [3:0] MODE_B_WRITE     = 4'd7;
  localparam logic [3:0] MODE_B_DDR       = 4'd8;
  localparam logic [3:0] MODE_C_READ      = 4'd9;
  localparam logic [3:0] MODE_C_WRITE     = 4'd10;
  localparam logic [3:0] MODE_C_DDR       = 4'd11;

  // Port B strobe bits
  localparam int unsigned PB_LATCH_MAIN   = 1;
  localparam int unsigned PB_LATCH_ANSWER = 2;
  localparam int unsigned PB_SCROLL_LOW   = 3;
  localparam int unsigned PB_SCROLL_HIGH  = 4;

  // Status read bits
  localparam logic [7:0] STAT_MAIN_EMPTY   = 8'h02;
  localparam logic [7:0] STAT_ANSWER_EMPTY = 8'h04;

  // Port C input flag bits
  localparam logic [7:0] PC_FLAG0 = 8'h01;
  localparam logic [7:0] PC_FLAG1 = 8'h02;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       mcu_irq;
    logic [7:0] scroll_low;
    logic [7:0] scroll_high;
  } result_t;

  function automatic logic [7:0] mix_port(input logic [7:0] outv, input logic [7:0] inv,
                                          input logic [7:0] dir);
    return (outv & dir) | (inv & ~dir);
  endfunction

endpackage

@@ rtl/mmpi_in_stage.sv @@
// Input register of the mailbox port interface core.
// Depends on mmpi_pkg for the transaction type.
`timescale 1ns / 1ps

module mmpi_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mmpi_pkg::item_t in_item,
  input  logic           advance,
  output logic           in_stall,
  output logic           full,
  output mmpi_pkg::item_t item
);

  logic accept;

  // Hold the transaction while it cannot move on
  assign in_stall = full && !advance;
  assign accept   = in_valid && !in_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

@@ rtl/mmpi_mailbox.sv @@
// Mailbox flags, port registers and scroll latches; next-state and read logic.
// Depends on mmpi_pkg for access codes, bit positions and types.
`timescale 1ns / 1ps

module mmpi_mailbox (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              advance,
  input  mmpi_pkg::item_t   item,
  output mmpi_pkg::result_t result
);

  logic       board_variant;
  logic [7:0] main_to_mcu_byte, main_to_mcu_byte_next;
  logic [7:0] mcu_to_main_byte, mcu_to_main_byte_next;
  logic       main_pending, main_pending_next;
  logic       answer_pending, answer_pending_next;
  logic       irq_line, irq_line_next;
  logic [7:0] port_a_input, port_a_input_next;
  logic [7:0] port_a_output, port_a_output_next;
  logic [7:0] port_a_direction, port_a_direction_next;
  logic [7:0] port_b_output, port_b_output_next;
  logic [7:0] port_b_direction, port_b_direction_next;
  logic [7:0] port_c_output, port_c_output_next;
  logic [7:0] port_c_direction, port_c_direction_next;
  logic [7:0] scroll_low_reg, scroll_low_reg_next;
  logic [7:0] scroll_high_reg, scroll_high_reg_next;
  logic [7:0] fall, rise, cin, rd;

  // Port B strobe edges against the previous output
  assign fall = port_b_output & ~item.data & port_b_direction;
  assign rise = item.data & ~port_b_output & port_b_direction;

  // Port C input pins carry the flags, polarity by board
  always_comb begin
    cin = '0;
    if (!board_variant) begin
      if (main_pending)    cin = cin | mmpi_pkg::PC_FLAG0;
      if (!answer_pending) cin = cin | mmpi_pkg::PC_FLAG1;
    end else begin
      if (!main_pending)   cin = cin | mmpi_pkg::PC_FLAG0;
      if (answer_pending)  cin = cin | mmpi_pkg::PC_FLAG1;
    end
  end

  // Decode one access
  always_comb begin
    main_to_mcu_byte_next = main_to_mcu_byte;
    mcu_to_main_byte_next = mcu_to_main_byte;
    main_pending_next     = main_pending;
    answer_pending_next   = answer_pending;
    irq_line_next         = irq_line;
    port_a_input_next     = port_a_input;
    port_a_output_next    = port_a_output;
    port_a_direction_next = port_a_direction;
    port_b_output_next    = port_b_output;
    port_b_direction_next = port_b_direction;
    port_c_output_next    = port_c_output;
    port_c_direction_next = port_c_direction;
    scroll_low_reg_next   = scroll_low_reg;
    scroll_high_reg_next  = scroll_high_reg;
    rd = '0;
    case (item.mode)
      mmpi_pkg::MODE_MAIN_WRITE: begin
        main_to_mcu_byte_next = item.data;
        main_pending_next     = 1'b1;
        if (board_variant) answer_pending_next = 1'b0;
        irq_line_next         = 1'b1;
      end
      mmpi_pkg::MODE_MAIN_READ: begin
        answer_pending_next = 1'b0;
        rd = mcu_to_main_byte;
      end
      mmpi_pkg::MODE_MAIN_STATUS: begin
        if (!main_pending)   rd = rd | mmpi_pkg::STAT_MAIN_EMPTY;
        if (!answer_pending) rd = rd | mmpi_pkg::STAT_ANSWER_EMPTY;
      end
      mmpi_pkg::MODE_A_READ: begin
        rd = mmpi_pkg::mix_port(port_a_output, port_a_input, port_a_direction);
      end
      mmpi_pkg::MODE_A_WRITE: begin
        port_a_output_next = item.data;
        if (board_variant) begin
          mcu_to_main_byte_next = item.data;
          answer_pending_next   = 1'b1;
        end
      end
      mmpi_pkg::MODE_A_DDR: begin
        port_a_direction_next = item.data;
      end
      mmpi_pkg::MODE_B_READ: begin
        rd = mmpi_pkg::mix_port(port_b_output, 8'h00, port_b_direction);
      end
      mmpi_pkg::MODE_B_WRITE: begin
        if (fall[mmpi_pkg::PB_LATCH_MAIN]) begin
          port_a_input_next = main_to_mcu_byte;
          if (main_pending) irq_line_next = 1'b0;
          main_pending_next = 1'b0;
        end
        if (rise[mmpi_pkg::PB_LATCH_ANSWER]) begin
          mcu_to_main_byte_next = port_a_output;
          answer_pending_next   = 1'b1;
        end
        if (!board_variant) begin
          if (fall[mmpi_pkg::PB_SCROLL_LOW])  scroll_low_reg_next  = port_a_output;
          if (fall[mmpi_pkg::PB_SCROLL_HIGH]) scroll_high_reg_next = port_a_output;
        end
        port_b_output_next = item.data;
      end
      mmpi_pkg::MODE_B_DDR: begin
        port_b_direction_next = item.data;
      end
      mmpi_pkg::MODE_C_READ: begin
        rd = mmpi_pkg::mix_port(port_c_output, cin, port_c_direction);
      end
      mmpi_pkg::MODE_C_WRITE: begin
        port_c_output_next = item.data;
      end
      mmpi_pkg::MODE_C_DDR: begin
        port_c_direction_next = item.data;
      end
      default: begin
      end
    endcase
  end

  // Read data reflects the state before the access; irq and scroll latches the state after it
  assign result.read_data   = rd;
  assign result.mcu_irq     = irq_line_next;
  assign result.scroll_low  = scroll_low_reg_next;
  assign result.scroll_high = scroll_high_reg_next;

  // Board select register
  always_ff @(posedge clk) begin
    if (rst) begin
      board_variant <= 1'b0;
    end else if (cfg_we) begin
      board_variant <= cfg_wdata;
    end
  end

  // Commit the access as it moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      main_to_mcu_byte <= '0;
      mcu_to_main_byte <= '0;
      main_pending     <= 1'b0;
      answer_pending   <= 1'b0;
      irq_line         <= 1'b0;
      port_a_input     <= '0;
      port_a_output    <= '0;
      port_a_direction <= '0;
      port_b_output    <= '0;
      port_b_direction <= '0;
      port_c_output    <= '0;
      port_c_direction <= '0;
      scroll_low_reg   <= '0;
      scroll_high_reg  <= '0;
    end else if (advance) begin
      main_to_mcu_byte <= main_to_mcu_byte_next;
      mcu_to_main_byte <= mcu_to_main_byte_next;
      main_pending     <= main_pending_next;
      answer_pending   <= answer_pending_next;
      irq_line         <= irq_line_next;
      port_a_input     <= port_a_input_next;
      port_a_output    <= port_a_output_next;
      port_a_direction <= port_a_direction_next;
      port_b_output    <= port_b_output_next;
      port_b_direction <= port_b_direction_next;
      port_c_output    <= port_c_output_next;
      port_c_direction <= port_c_direction_next;
      scroll_low_reg   <= scroll_low_reg_next;
      scroll_high_reg  <= scroll_high_reg_next;
    end
  end

endmodule

@@ rtl/mmpi_out_stage.sv @@
// Result register of the mailbox port interface core.
// Depends on mmpi_pkg for the result type.
`timescale 1ns / 1ps

module mmpi_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  mmpi_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output mmpi_pkg::result_t result
);

  // Hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the new result
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_in;
    end
  end

endmodule

@@ rtl/mcu_mailbox_port_interface_core.sv @@
// Channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// in        | in_valid / in_stall  | mode[3:0], data[7:0]
// out       | out_valid / out_stall| read_data[7:0], mcu_irq, scroll_low, scroll_high
// cfg       | cfg_we               | cfg_wdata (board select)
//
// One access per cycle while in_stall is low; each access passes the input register,
// then the mailbox update into the result register, from which it is presented.
// rst is synchronous and clears all flags, ports, latches and the board select.
// While out_stall holds a result, the input register still takes one access;
// in_stall rises only when both registers are occupied.
// Top level of the mailbox port interface core; uses mmpi_pkg, the stage
// modules and the assertion macro header.
`timescale 1ns / 1ps
`include "mcu_mailbox_port_interface_core_defines.svh"

module mcu_mailbox_port_interface_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] mode,
  input  logic [7:0] data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       mcu_irq,
  output logic [7:0] scroll_low,
  output logic [7:0] scroll_high
);

  mmpi_pkg::item_t   in_item;
  mmpi_pkg::item_t   item;
  mmpi_pkg::result_t result_next;
  mmpi_pkg::result_t result;
  logic              full;
  logic              advance;

  assign in_item.mode = mode;
  assign in_item.data = data;

  // Move the held transaction on when the result register frees up
  assign advance = full && (!out_valid || !out_stall);

  mmpi_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_stall (in_stall),
    .full     (full),
    .item     (item)
  );

  mmpi_mailbox u_mailbox (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result_next)
  );

  mmpi_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result_in (result_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (result)
  );

  assign read_data   = result.read_data;
  assign mcu_irq     = result.mcu_irq;
  assign scroll_low  = result.scroll_low;
  assign scroll_high = result.scroll_high;

  // Input side stalls only behind a full, stalled output
  `MMPI_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, full && out_valid && out_stall)
  // An advanced transaction always shows up as a result
  `MMPI_ASSERT_NEXT(a_advance_shows, clk, rst, advance, out_valid)
  // A taken result with nothing behind it is not repeated
  `MMPI_ASSERT_NEXT(a_no_repeat, clk, rst, out_valid && !out_stall && !advance, !out_valid)

endmodule
